// ----- src/ffbe_pkg.sv -----
// Package for the FASTA/FASTQ base extractor: beat types, format codes and
// the character constants used by the parser. No dependencies.
package ffbe_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] SepReset = 8'h4E;  // 'N'
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChTab    = 8'h09;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChGt     = 8'h3E;
  localparam logic [ByteW-1:0] ChAt     = 8'h40;

  // FASTQ line index of the sequence line within a four-line record
  localparam logic [1:0] SeqLine = 2'd1;

  typedef enum logic [3:0] {
    MODE_UNKNOWN = 4'b0001,
    MODE_FASTA   = 4'b0010,
    MODE_FASTQ   = 4'b0100,
    MODE_ERROR   = 4'b1000
  } mode_e;

  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             file_start;
  } in_beat_t;

  typedef struct packed {
    logic [ByteW-1:0] base_byte;
    logic             is_separator;
    logic             format_error;
  } out_beat_t;

  function automatic logic is_blank(input logic [ByteW-1:0] c);
    return (c == ChLf) || (c == ChCr) || (c == ChSpace) || (c == ChTab);
  endfunction

endpackage

// ----- src/fasta_fastq_base_extractor.sv -----
// Top level of the FASTA/FASTQ base extractor: byte parser, result register
// and skid stage. Depends on ffbe_pkg.
//
// Takes one file byte per beat and emits only sequence bases, with a flagged
// separator beat between records and a single error beat when the first
// non-blank byte is neither '>' nor '@'. One byte is taken every cycle while
// the input is not stalled; the parse is a few state bits updated in the
// same cycle as the byte is taken, and each result is registered in the
// output register, or in the one-entry skid stage while the output is
// stalled. The skid stage lets input keep flowing while the output is
// stalled; the input stalls only when the skid stage is full. The
// separator register is written through the cfg port, which is always ready.
module fasta_fastq_base_extractor (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  ffbe_pkg::in_beat_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ffbe_pkg::out_beat_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_data_i
);

  logic [ffbe_pkg::ByteW-1:0] sep_q;

  ffbe_pkg::mode_e mode_q, mode_d;
  logic            record_seen_q, record_seen_d;
  logic            in_header_q, in_header_d;
  logic [1:0]      phase_q, phase_d;
  logic            await_q, await_d;

  logic                out_valid_q, skid_valid_q;
  ffbe_pkg::out_beat_t out_q, skid_q;

  logic                accept;
  logic                res_valid;
  ffbe_pkg::out_beat_t res;
  logic                out_fire;

  assign accept      = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;
  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic [ffbe_pkg::ByteW-1:0] c;
    ffbe_pkg::mode_e            mode_w;
    logic                       seen_w, hdr_w, await_w;
    logic [1:0]                 phase_w, phase_n;

    c       = in_data_i.data_byte;
    mode_w  = mode_q;
    seen_w  = record_seen_q;
    hdr_w   = in_header_q;
    phase_w = phase_q;
    await_w = await_q;
    if (in_data_i.file_start) begin
      mode_w  = ffbe_pkg::MODE_UNKNOWN;
      seen_w  = 1'b0;
      hdr_w   = 1'b0;
      phase_w = 2'd0;
      await_w = 1'b1;
    end

    phase_n   = phase_w + 2'd1;
    res_valid = 1'b0;
    res       = '{base_byte: c, is_separator: 1'b0, format_error: 1'b0};

    // Resolve the format first; the selecting byte is then parsed again below.
    if (mode_w == ffbe_pkg::MODE_UNKNOWN && !ffbe_pkg::is_blank(c)) begin
      if (c == ffbe_pkg::ChGt) begin
        mode_w = ffbe_pkg::MODE_FASTA;
      end else if (c == ffbe_pkg::ChAt) begin
        mode_w = ffbe_pkg::MODE_FASTQ;
      end else begin
        mode_w    = ffbe_pkg::MODE_ERROR;
        res_valid = 1'b1;
        res       = '{base_byte: '0, is_separator: 1'b0, format_error: 1'b1};
      end
    end

    case (mode_w)
      ffbe_pkg::MODE_FASTA: begin
        if (c == ffbe_pkg::ChGt) begin
          res_valid = seen_w;
          res       = '{base_byte: sep_q, is_separator: 1'b1, format_error: 1'b0};
          seen_w    = 1'b1;
          hdr_w     = 1'b1;
        end else if (c == ffbe_pkg::ChLf || c == ffbe_pkg::ChCr) begin
          hdr_w = 1'b0;
        end else if (!hdr_w && c != ffbe_pkg::ChSpace && c != ffbe_pkg::ChTab) begin
          res_valid = 1'b1;
        end
      end
      ffbe_pkg::MODE_FASTQ: begin
        if (c == ffbe_pkg::ChLf) begin
          phase_w = phase_n;
          if (phase_n == ffbe_pkg::SeqLine) begin
            res_valid = !await_w;
            res       = '{base_byte: sep_q, is_separator: 1'b1, format_error: 1'b0};
            await_w   = 1'b0;
          end
        end else if (c != ffbe_pkg::ChCr && phase_w == ffbe_pkg::SeqLine &&
                     c != ffbe_pkg::ChSpace && c != ffbe_pkg::ChTab) begin
          res_valid = 1'b1;
        end
      end
      default: begin
        // unknown (blank skipped) or error: hold
      end
    endcase

    mode_d        = mode_w;
    record_seen_d = seen_w;
    in_header_d   = hdr_w;
    phase_d       = phase_w;
    await_d       = await_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q         <= ffbe_pkg::SepReset;
      mode_q        <= ffbe_pkg::MODE_UNKNOWN;
      record_seen_q <= 1'b0;
      in_header_q   <= 1'b0;
      phase_q       <= 2'd0;
      await_q       <= 1'b1;
      out_valid_q   <= 1'b0;
      skid_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        sep_q <= cfg_data_i;
      end
      if (accept) begin
        mode_q        <= mode_d;
        record_seen_q <= record_seen_d;
        in_header_q   <= in_header_d;
        phase_q       <= phase_d;
        await_q       <= await_d;
      end
      if (out_fire || !out_valid_q) begin
        // output slot frees up: drain skid first, else take the new result
        if (skid_valid_q) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= accept && res_valid;
        end
      end else if (accept && res_valid) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (accept && res_valid) begin
        out_q <= res;
      end
    end else if (accept && res_valid) begin
      skid_q <= res;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid stage holds a beat while output register is empty");

  a_error_beat_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.format_error) |->
      (out_data_o.base_byte == '0 && !out_data_o.is_separator))
    else $error("error beat carries data or separator flag");

  a_error_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && mode_q == ffbe_pkg::MODE_ERROR && !in_data_i.file_start &&
     !out_valid_q) |=> !out_valid_o)
    else $error("byte in sticky error mode produced a result");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_stall_i) |=> (skid_valid_q && $stable(skid_q)))
    else $error("skid beat lost or changed while output stalled");

endmodule
